### sv/tlt_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the tensor layout transposer.
// No dependencies; imported by tlt_stride_unit and tensor_layout_transpose.
package tlt_pkg;

    localparam int CFG_INDEX_BITS = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIM_OUTER  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIM_SECOND = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIM_THIRD  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIM_FOURTH = 3'd4;

    // Layout modes
    localparam logic [1:0] MODE_IDENTITY  = 2'd0;
    localparam logic [1:0] MODE_NHWC_NCHW = 2'd1;
    localparam logic [1:0] MODE_NCHW_NHWC = 2'd2;
    localparam logic [1:0] MODE_MATRIX    = 2'd3;

    // Status of the stride sequencer
    typedef struct packed {
        logic busy;       // recomputing strides and offsets
        logic done;       // one-cycle pulse: load fresh offset terms
        logic too_large;  // element count exceeds 2^32-1
    } tlt_status_t;

endpackage

### sv/tlt_stride_unit.sv
`timescale 1ns / 1ps
// Stride sequencer: after a configuration write, derives per-axis strides,
// the oversize flag and the offset terms of the current indices. Uses tlt_pkg.
module tlt_stride_unit
    import tlt_pkg::*;
#(
    parameter int DIM_BITS    = 16,
    parameter int OFFSET_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [1:0]             mode,
    input  logic [DIM_BITS-1:0]    d0,
    input  logic [DIM_BITS-1:0]    d1,
    input  logic [DIM_BITS-1:0]    d2,
    input  logic [DIM_BITS-1:0]    d3m,
    input  logic [DIM_BITS-1:0]    idx0,
    input  logic [DIM_BITS-1:0]    idx1,
    input  logic [DIM_BITS-1:0]    idx2,
    input  logic [DIM_BITS-1:0]    idx3,
    output logic [OFFSET_BITS-1:0] inner,
    output logic [OFFSET_BITS-1:0] s1,
    output logic [OFFSET_BITS-1:0] s2,
    output logic [OFFSET_BITS-1:0] s3,
    output logic [OFFSET_BITS-1:0] base_init,
    output logic [OFFSET_BITS-1:0] c1_init,
    output logic [OFFSET_BITS-1:0] c2_init,
    output logic [OFFSET_BITS-1:0] c3_init,
    output tlt_status_t            status
);

    localparam int AW = (OFFSET_BITS > 33) ? OFFSET_BITS : 33;
    localparam int PW = AW + DIM_BITS;

    typedef enum logic [3:0] {
        ST_D1D2,
        ST_INNER,
        ST_D1D3,
        ST_D2D3,
        ST_CNT01,
        ST_CNT2,
        ST_CNT3,
        ST_BASE,
        ST_C1,
        ST_C2,
        ST_C3
    } step_t;

    step_t                  step_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic                   too_large_reg;
    logic [OFFSET_BITS-1:0] t12_reg;
    logic [OFFSET_BITS-1:0] t123_reg;
    logic [OFFSET_BITS-1:0] t13_reg;
    logic [OFFSET_BITS-1:0] t23_reg;
    logic [32:0]            cnt_reg;
    logic [OFFSET_BITS-1:0] inner_reg;
    logic [OFFSET_BITS-1:0] s1_reg;
    logic [OFFSET_BITS-1:0] s2_reg;
    logic [OFFSET_BITS-1:0] s3_reg;
    logic [OFFSET_BITS-1:0] base_init_reg;
    logic [OFFSET_BITS-1:0] c1_init_reg;
    logic [OFFSET_BITS-1:0] c2_init_reg;
    logic [OFFSET_BITS-1:0] c3_init_reg;

    logic [OFFSET_BITS-1:0] s1_sel;
    logic [OFFSET_BITS-1:0] s2_sel;
    logic [OFFSET_BITS-1:0] s3_sel;
    logic [AW-1:0]          op_a;
    logic [DIM_BITS-1:0]    op_b;
    logic [PW-1:0]          prod;
    logic [OFFSET_BITS-1:0] prod_off;
    logic [32:0]            prod_sat;

    // Stride per input axis, by mode
    always_comb
    begin
        case (mode)
            MODE_IDENTITY:
            begin
                s1_sel = t23_reg;
                s2_sel = OFFSET_BITS'(d3m);
                s3_sel = OFFSET_BITS'(1);
            end
            MODE_NHWC_NCHW:
            begin
                s1_sel = OFFSET_BITS'(d2);
                s2_sel = OFFSET_BITS'(1);
                s3_sel = t12_reg;
            end
            MODE_NCHW_NHWC:
            begin
                s1_sel = OFFSET_BITS'(1);
                s2_sel = t13_reg;
                s3_sel = OFFSET_BITS'(d1);
            end
            default:
            begin
                s1_sel = OFFSET_BITS'(1);
                s2_sel = OFFSET_BITS'(d1);
                s3_sel = '0;
            end
        endcase
    end

    // Shared multiplier operands
    always_comb
    begin
        case (step_reg)
            ST_D1D2:  begin op_a = AW'(d1);        op_b = d2;   end
            ST_INNER: begin op_a = AW'(t12_reg);   op_b = d3m;  end
            ST_D1D3:  begin op_a = AW'(d1);        op_b = d3m;  end
            ST_D2D3:  begin op_a = AW'(d2);        op_b = d3m;  end
            ST_CNT01: begin op_a = AW'(d0);        op_b = d1;   end
            ST_CNT2:  begin op_a = AW'(cnt_reg);   op_b = d2;   end
            ST_CNT3:  begin op_a = AW'(cnt_reg);   op_b = d3m;  end
            ST_BASE:  begin op_a = AW'(t123_reg);  op_b = idx0; end
            ST_C1:    begin op_a = AW'(s1_sel);    op_b = idx1; end
            ST_C2:    begin op_a = AW'(s2_sel);    op_b = idx2; end
            ST_C3:    begin op_a = AW'(s3_sel);    op_b = idx3; end
            default:  begin op_a = '0;             op_b = '0;   end
        endcase
    end

    assign prod     = PW'(op_a) * PW'(op_b);
    assign prod_off = prod[OFFSET_BITS-1:0];
    // Saturate the element count at 2^32
    assign prod_sat = (|prod[PW-1:32]) ? {1'b1, 32'b0} : prod[32:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_D1D2;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            too_large_reg <= 1'b0;
            inner_reg     <= OFFSET_BITS'(1);
            s1_reg        <= OFFSET_BITS'(1);
            s2_reg        <= OFFSET_BITS'(1);
            s3_reg        <= OFFSET_BITS'(1);
            base_init_reg <= '0;
            c1_init_reg   <= '0;
            c2_init_reg   <= '0;
            c3_init_reg   <= '0;
            t12_reg       <= '0;
            t123_reg      <= '0;
            t13_reg       <= '0;
            t23_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= ST_D1D2;
            end
            else if (busy_reg)
            begin
                case (step_reg)
                    ST_D1D2:  begin t12_reg  <= prod_off; step_reg <= ST_INNER; end
                    ST_INNER: begin t123_reg <= prod_off; step_reg <= ST_D1D3;  end
                    ST_D1D3:  begin t13_reg  <= prod_off; step_reg <= ST_D2D3;  end
                    ST_D2D3:  begin t23_reg  <= prod_off; step_reg <= ST_CNT01; end
                    ST_CNT01: begin cnt_reg  <= prod_sat; step_reg <= ST_CNT2;  end
                    ST_CNT2:  begin cnt_reg  <= prod_sat; step_reg <= ST_CNT3;  end
                    ST_CNT3:
                    begin
                        too_large_reg <= prod_sat[32];
                        step_reg      <= ST_BASE;
                    end
                    ST_BASE:  begin base_init_reg <= prod_off; step_reg <= ST_C1; end
                    ST_C1:    begin c1_init_reg   <= prod_off; step_reg <= ST_C2; end
                    ST_C2:    begin c2_init_reg   <= prod_off; step_reg <= ST_C3; end
                    ST_C3:
                    begin
                        c3_init_reg <= prod_off;
                        inner_reg   <= t123_reg;
                        s1_reg      <= s1_sel;
                        s2_reg      <= s2_sel;
                        s3_reg      <= s3_sel;
                        busy_reg    <= 1'b0;
                        done_reg    <= 1'b1;
                        step_reg    <= ST_D1D2;
                    end
                    default:
                    begin
                        busy_reg <= 1'b0;
                        step_reg <= ST_D1D2;
                    end
                endcase
            end
        end
    end

    assign inner            = inner_reg;
    assign s1               = s1_reg;
    assign s2               = s2_reg;
    assign s3               = s3_reg;
    assign base_init        = base_init_reg;
    assign c1_init          = c1_init_reg;
    assign c2_init          = c2_init_reg;
    assign c3_init          = c3_init_reg;
    assign status.busy      = busy_reg;
    assign status.done      = done_reg;
    assign status.too_large = too_large_reg;

endmodule

### sv/tensor_layout_transpose.sv
`timescale 1ns / 1ps
// An accepted byte appears as a result transaction in the next cycle.
// Throughput: one byte per cycle while byte_stall is low, set by the index counters and offset adders.
// After each configuration write the input stalls while the
// stride sequencer runs its shared multiplier through 11 steps.
// Reset: mode 0, all dimensions 1, indices and offsets zero, no result pending.
// Depends on tlt_pkg and tlt_stride_unit.
module tensor_layout_transpose
    import tlt_pkg::*;
#(
    parameter int DIM_BITS    = 16,
    parameter int OFFSET_BITS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // byte input channel
    input  logic                      byte_valid,
    output logic                      byte_stall,
    input  logic [7:0]                in_byte,
    // result channel
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic [7:0]                out_byte,
    output logic [31:0]               dest_offset,
    output logic                      last,
    output logic                      too_large,
    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [DIM_BITS-1:0]       cfg_data
);

    localparam int OW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

    // Configuration registers
    logic [1:0]             mode_reg;
    logic [DIM_BITS-1:0]    dim0_reg;
    logic [DIM_BITS-1:0]    dim1_reg;
    logic [DIM_BITS-1:0]    dim2_reg;
    logic [DIM_BITS-1:0]    dim3_reg;

    // Input position of the next byte and its offset terms
    logic [DIM_BITS-1:0]    idx0_reg, idx0_next;
    logic [DIM_BITS-1:0]    idx1_reg, idx1_next;
    logic [DIM_BITS-1:0]    idx2_reg, idx2_next;
    logic [DIM_BITS-1:0]    idx3_reg, idx3_next;
    logic [OFFSET_BITS-1:0] base_reg, base_next;
    logic [OFFSET_BITS-1:0] c1_reg, c1_next;
    logic [OFFSET_BITS-1:0] c2_reg, c2_next;
    logic [OFFSET_BITS-1:0] c3_reg, c3_next;

    // Result register
    logic                   result_valid_reg;
    logic [7:0]             out_byte_reg;
    logic [31:0]            dest_reg;
    logic                   last_reg;
    logic                   too_large_reg;

    logic                   matrix;
    logic [DIM_BITS-1:0]    d0, d1, d2, d3m;
    logic [OFFSET_BITS-1:0] inner, s1, s2, s3;
    logic [OFFSET_BITS-1:0] base_init, c1_init, c2_init, c3_init;
    tlt_status_t            status;
    logic                   cfg_write;
    logic                   accept;
    logic                   wrap0, wrap1, wrap2, wrap3;
    logic                   last_now;
    logic [OFFSET_BITS-1:0] dest_now;
    logic [OW-1:0]          dest_ext;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Hold input while strides are rebuilt, while a write is pending, or
    // while a finished result waits on a stalled receiver.
    assign byte_stall = status.busy || status.done || cfg_valid ||
                        (result_valid_reg && result_stall);
    assign accept     = byte_valid && !byte_stall;

    // A zero dimension acts as size one; matrix mode drops the fourth axis.
    assign matrix = (mode_reg == MODE_MATRIX);
    assign d0  = (dim0_reg == '0) ? DIM_BITS'(1) : dim0_reg;
    assign d1  = (dim1_reg == '0) ? DIM_BITS'(1) : dim1_reg;
    assign d2  = (dim2_reg == '0) ? DIM_BITS'(1) : dim2_reg;
    assign d3m = (matrix || dim3_reg == '0) ? DIM_BITS'(1) : dim3_reg;

    tlt_stride_unit #(
        .DIM_BITS    (DIM_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_stride (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cfg_write),
        .mode      (mode_reg),
        .d0        (d0),
        .d1        (d1),
        .d2        (d2),
        .d3m       (d3m),
        .idx0      (idx0_reg),
        .idx1      (idx1_reg),
        .idx2      (idx2_reg),
        .idx3      (idx3_reg),
        .inner     (inner),
        .s1        (s1),
        .s2        (s2),
        .s3        (s3),
        .base_init (base_init),
        .c1_init   (c1_init),
        .c2_init   (c2_init),
        .c3_init   (c3_init),
        .status    (status)
    );

    // An index at or above its last value wraps to zero and carries.
    // In matrix mode the fourth size is one, so that axis always wraps.
    assign wrap3    = (idx3_reg >= d3m - DIM_BITS'(1));
    assign wrap2    = (idx2_reg >= d2 - DIM_BITS'(1));
    assign wrap1    = (idx1_reg >= d1 - DIM_BITS'(1));
    assign wrap0    = (idx0_reg >= d0 - DIM_BITS'(1));
    assign last_now = wrap0 && wrap1 && wrap2 && wrap3;

    // Output offset is the sum of the per-axis terms, modulo 2^OFFSET_BITS.
    assign dest_now = base_reg + c1_reg + c2_reg + c3_reg;
    assign dest_ext = OW'(dest_now);

    // Load fresh offset terms when the sequencer is done; else advance counters and running offset terms by one byte
    always_comb
    begin
        idx0_next = idx0_reg;
        idx1_next = idx1_reg;
        idx2_next = idx2_reg;
        idx3_next = idx3_reg;
        base_next = base_reg;
        c1_next   = c1_reg;
        c2_next   = c2_reg;
        c3_next   = c3_reg;
        if (status.done)
        begin
            base_next = base_init;
            c1_next   = c1_init;
            c2_next   = c2_init;
            c3_next   = c3_init;
        end
        else if (accept)
        begin
            idx3_next = wrap3 ? '0 : idx3_reg + DIM_BITS'(1);
            c3_next   = wrap3 ? '0 : c3_reg + s3;
            if (wrap3)
            begin
                idx2_next = wrap2 ? '0 : idx2_reg + DIM_BITS'(1);
                c2_next   = wrap2 ? '0 : c2_reg + s2;
                if (wrap2)
                begin
                    idx1_next = wrap1 ? '0 : idx1_reg + DIM_BITS'(1);
                    c1_next   = wrap1 ? '0 : c1_reg + s1;
                    if (wrap1)
                    begin
                        idx0_next = wrap0 ? '0 : idx0_reg + DIM_BITS'(1);
                        base_next = wrap0 ? '0 : base_reg + inner;
                    end
                end
            end
        end
    end

    // Configuration registers; writes to unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDENTITY;
            dim0_reg <= DIM_BITS'(1);
            dim1_reg <= DIM_BITS'(1);
            dim2_reg <= DIM_BITS'(1);
            dim3_reg <= DIM_BITS'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MODE:       mode_reg <= cfg_data[1:0];
                REG_DIM_OUTER:  dim0_reg <= cfg_data;
                REG_DIM_SECOND: dim1_reg <= cfg_data;
                REG_DIM_THIRD:  dim2_reg <= cfg_data;
                REG_DIM_FOURTH: dim3_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Index counters and offset terms
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx0_reg <= '0;
            idx1_reg <= '0;
            idx2_reg <= '0;
            idx3_reg <= '0;
            base_reg <= '0;
            c1_reg   <= '0;
            c2_reg   <= '0;
            c3_reg   <= '0;
        end
        else
        begin
            idx0_reg <= idx0_next;
            idx1_reg <= idx1_next;
            idx2_reg <= idx2_next;
            idx3_reg <= idx3_next;
            base_reg <= base_next;
            c1_reg   <= c1_next;
            c2_reg   <= c2_next;
            c3_reg   <= c3_next;
        end
    end

    // Result register: load on accept, drop once the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_byte_reg  <= in_byte;
            dest_reg      <= dest_ext[31:0];
            last_reg      <= last_now;
            too_large_reg <= status.too_large;
        end
    end

    assign result_valid = result_valid_reg;
    assign out_byte     = out_byte_reg;
    assign dest_offset  = dest_reg;
    assign last         = last_reg;
    assign too_large    = too_large_reg;

    // No byte enters while the sequencer rebuilds strides
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !status.busy && !status.done)
        else $error("byte accepted during stride rebuild");

    // A configuration write holds off input on the following cycle
    a_cfg_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> byte_stall)
        else $error("input not stalled after configuration write");

    // The final element returns every counter to zero
    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_now |=> idx0_reg == '0 && idx1_reg == '0 &&
                               idx2_reg == '0 && idx3_reg == '0 &&
                               base_reg == '0 && c1_reg == '0 &&
                               c2_reg == '0 && c3_reg == '0)
        else $error("counters not cleared after final element");

    // Matrix mode clears the fourth index on every advance
    a_matrix_fourth: assert property (@(posedge clk) disable iff (!rst_n)
        accept && matrix |=> idx3_reg == '0 && c3_reg == '0)
        else $error("fourth axis advanced in matrix mode");

endmodule

### tb/tb_tensor_layout_transpose.sv
`timescale 1ns / 1ps
// Self-checking testbench for tensor_layout_transpose: streams bytes, predicts each
// byte's destination offset and flags, and checks every result transaction in order.
// Depends on tlt_pkg and the tensor_layout_transpose RTL.
module tb_tensor_layout_transpose
    import tlt_pkg::*;
();

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_BYTES  = 1500;

    // One expected (or observed) result transaction
    typedef struct packed {
        logic [7:0]  data;
        logic [31:0] offset;
        logic        last;
        logic        oversize;
    } placement_t;

    logic                      clk;
    logic                      rst_n        = 1'b0;
    logic                      byte_valid   = 1'b0;
    logic                      byte_stall;
    logic [7:0]                in_byte      = 8'd0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    logic [7:0]                out_byte;
    logic [31:0]               dest_offset;
    logic                      last;
    logic                      too_large;
    logic                      cfg_valid    = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
    logic [15:0]               cfg_data     = 16'd0;

    // Shadow of the block: layout registers and the input walk position
    logic [1:0]  layout_mode;
    bit   [15:0] shape_dim [4];
    bit   [63:0] walk_pos  [4];

    placement_t placement_q [$];
    int         mismatches  = 0;
    int         cycle_count = 0;
    int         stall_pct   = 30;
    int         stall_hold  = 0;

    tensor_layout_transpose dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .in_byte      (in_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .dest_offset  (dest_offset),
        .last         (last),
        .too_large    (too_large),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Abort a hung run; the limit is many times the slowest correct run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: hold stall high or low for random runs, at a density set per phase.
    always @(posedge clk)
    begin
        if (stall_hold != 0)
            stall_hold <= stall_hold - 1;
        else
        begin
            result_stall <= ($urandom_range(0, 99) < stall_pct);
            stall_hold   <= $urandom_range(0, 7);
        end
    end

    // Work out where one byte lands, then advance the walk position
    // (innermost axis fastest, each axis wraps to zero and carries outward).
    function automatic placement_t place_byte(input logic [7:0] b);
        bit [63:0]  d [4];
        bit [63:0]  i [4];
        bit [63:0]  base;
        bit [63:0]  dest;
        bit [63:0]  count;
        bit         matrix;
        bit         carry;
        int         k;
        placement_t p;
        matrix = (layout_mode == MODE_MATRIX);
        for (k = 0; k < 4; k++)
        begin
            // a zero dimension register counts as size one
            d[k] = (shape_dim[k] == 16'd0) ? 64'd1 : 64'(shape_dim[k]);
            i[k] = walk_pos[k];
        end
        // matrix mode drops the fourth axis entirely
        if (matrix)
        begin
            d[3] = 64'd1;
            i[3] = 64'd0;
        end
        base = i[0] * (d[1] * d[2] * d[3]);
        case (layout_mode)
            MODE_NHWC_NCHW: dest = base + i[3] * (d[1] * d[2]) + i[1] * d[2] + i[2];
            MODE_NCHW_NHWC: dest = base + (i[2] * d[3] + i[3]) * d[1] + i[1];
            MODE_MATRIX:    dest = base + i[2] * d[1] + i[1];
            default:        dest = ((i[0] * d[1] + i[1]) * d[2] + i[2]) * d[3] + i[3];
        endcase
        count      = d[0] * d[1] * d[2] * d[3];
        p.data     = b;
        p.offset   = dest[31:0];
        p.last     = (i[0] + 1 >= d[0]) && (i[1] + 1 >= d[1]) &&
                     (i[2] + 1 >= d[2]) && (i[3] + 1 >= d[3]);
        p.oversize = (count > 64'h0000_0000_FFFF_FFFF);
        // an index at or past its last value wraps on the next advance
        walk_pos[3] = i[3];
        carry = 1'b1;
        for (k = 3; k >= 0; k--)
        begin
            if (carry)
            begin
                if (walk_pos[k] + 1 >= d[k])
                    walk_pos[k] = 64'd0;
                else
                begin
                    walk_pos[k] = walk_pos[k] + 1;
                    carry = 1'b0;
                end
            end
        end
        return p;
    endfunction

    // Check each accepted result transaction against the oldest prediction.
    always @(posedge clk)
    begin
        placement_t got;
        placement_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            got = '{data: out_byte, offset: dest_offset, last: last, oversize: too_large};
            if (placement_q.size() == 0)
            begin
                if (mismatches < REPORT_LIMIT)
                    $display("unexpected result: byte %h offset %h last %b too_large %b",
                             got.data, got.offset, got.last, got.oversize);
                mismatches++;
            end
            else
            begin
                want = placement_q.pop_front();
                if (got !== want)
                begin
                    if (mismatches < REPORT_LIMIT)
                    begin
                        $write("mismatch (expected/actual): byte %h/%h offset %h/%h ",
                               want.data, got.data, want.offset, got.offset);
                        $display("last %b/%b too_large %b/%b",
                                 want.last, got.last, want.oversize, got.oversize);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Offer one byte and hold it until accepted, then record its prediction.
    task automatic send_byte(input logic [7:0] b);
        byte_valid <= 1'b1;
        in_byte    <= b;
        do
            @(posedge clk);
        while (byte_stall);
        placement_q.push_back(place_byte(b));
    endtask

    // Stream random bytes in bursts; when gappy, drop valid for a random gap between bursts.
    task automatic stream_bytes(input int n, input bit gappy);
        int burst;
        int gap;
        int k;
        burst = 0;
        for (k = 0; k < n; k++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 24);
                gap   = gappy ? $urandom_range(0, 5) : 0;
                if (gap != 0)
                begin
                    byte_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            send_byte(8'($urandom_range(0, 255)));
            burst--;
        end
        byte_valid <= 1'b0;
    endtask

    // Wait until every predicted result has come back; registers change only then.
    task automatic wait_idle();
        byte_valid <= 1'b0;
        while (placement_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Write one register and mirror it into the shadow.
    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MODE:       layout_mode  = value[1:0];
            REG_DIM_OUTER:  shape_dim[0] = value;
            REG_DIM_SECOND: shape_dim[1] = value;
            REG_DIM_THIRD:  shape_dim[2] = value;
            REG_DIM_FOURTH: shape_dim[3] = value;
            default:        ;
        endcase
        @(posedge clk);
    endtask

    // Program a full layout; junk in the unused mode bits must be dropped.
    task automatic set_layout(input logic [1:0] m, input logic [15:0] d0, input logic [15:0] d1,
                              input logic [15:0] d2, input logic [15:0] d3);
        logic [15:0] mode_word;
        mode_word = {16'($urandom) & 16'hFFFC} | {14'd0, m};
        wait_idle();
        cfg_write(REG_MODE, mode_word);
        cfg_write(REG_DIM_OUTER, d0);
        cfg_write(REG_DIM_SECOND, d1);
        cfg_write(REG_DIM_THIRD, d2);
        cfg_write(REG_DIM_FOURTH, d3);
    endtask

    // Reset layout is a single-byte tensor: every byte is last, offset zero.
    task automatic test_reset_layout();
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    // Walk each mode on a tiny shape; counters carry over from phase to phase.
    task automatic test_each_mode();
        set_layout(MODE_IDENTITY, 16'd1, 16'd2, 16'd2, 16'd2);
        stream_bytes(4, 1'b0);
        set_layout(MODE_NHWC_NCHW, 16'd1, 16'd2, 16'd2, 16'd2);
        stream_bytes(4, 1'b1);
        set_layout(MODE_NCHW_NHWC, 16'd1, 16'd2, 16'd2, 16'd2);
        stream_bytes(4, 1'b0);
        set_layout(MODE_MATRIX, 16'd1, 16'd2, 16'd2, 16'd2);
        stream_bytes(4, 1'b1);
    endtask

    // Zero-sized axes behave as size one.
    task automatic test_zero_dims();
        set_layout(MODE_NHWC_NCHW, 16'd0, 16'd2, 16'd0, 16'd3);
        stream_bytes(3, 1'b0);
    endtask

    // Largest shape: element count overflows 32 bits and offsets wrap.
    task automatic test_oversized();
        set_layout(MODE_NHWC_NCHW, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        stream_bytes(3, 1'b0);
        set_layout(MODE_MATRIX, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
        stream_bytes(2, 1'b0);
    endtask

    // Shrink an axis below the live index mid-tensor; the index must wrap and carry.
    task automatic test_shrink_mid_tensor();
        set_layout(MODE_IDENTITY, 16'd1, 16'd2, 16'd1, 16'd20);
        stream_bytes(6, 1'b0);
        wait_idle();
        cfg_write(REG_DIM_FOURTH, 16'd3);
        stream_bytes(3, 1'b0);
    endtask

    // Writes to unmapped indexes leave the layout alone.
    task automatic test_unmapped_writes();
        logic [CFG_INDEX_BITS-1:0] idx;
        wait_idle();
        for (idx = CFG_INDEX_BITS'(REG_DIM_FOURTH + 1); idx != '0; idx++)
            cfg_write(idx, 16'hFFFF);
        stream_bytes(2, 1'b0);
    endtask

    // Random shapes, modes and traffic; mostly small shapes so tensors complete often.
    task automatic test_random_layouts();
        int          sent;
        int          n;
        int          k;
        int          kind;
        longint      elems;
        logic [15:0] dims [4];
        logic [1:0]  m;
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            m    = 2'($urandom_range(0, 3));
            kind = $urandom_range(0, 99);
            for (k = 0; k < 4; k++)
            begin
                if (kind < 85)
                    dims[k] = 16'($urandom_range(0, 5));
                else if (kind < 95)
                    dims[k] = 16'($urandom_range(1, 300));
                else
                    dims[k] = 16'($urandom);
            end
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 80);
            wait_idle();
            // occasionally rewrite only part of the layout
            if ($urandom_range(0, 4) == 0)
                cfg_write(3'($urandom_range(0, 7)), 16'($urandom));
            else
                set_layout(m, dims[0], dims[1], dims[2], dims[3]);
            if (kind < 85)
            begin
                elems = 1;
                for (k = 0; k < 4; k++)
                    if (!(k == 3 && layout_mode == MODE_MATRIX) && shape_dim[k] != 0)
                        elems = elems * shape_dim[k];
                if (elems > 150)
                    elems = 150;
                n = int'(elems) * $urandom_range(1, 2) + $urandom_range(0, 3);
            end
            else
                n = $urandom_range(1, 40);
            stream_bytes(n, $urandom_range(0, 3) != 0);
            sent += n;
        end
    endtask

    initial
    begin
        layout_mode = MODE_IDENTITY;
        for (int k = 0; k < 4; k++)
        begin
            shape_dim[k] = 16'd1;
            walk_pos[k]  = 64'd0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_layout();
        test_each_mode();
        test_zero_dims();
        test_oversized();
        test_shrink_mid_tensor();
        test_unmapped_writes();
        test_random_layouts();

        // Drain the pipe, then leave room for any stray transaction before the verdict.
        wait_idle();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
sv/tlt_pkg.sv
sv/tlt_stride_unit.sv
sv/tensor_layout_transpose.sv
tb/tb_tensor_layout_transpose.sv
